// ----- hdl/tgarle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// tgarle_pkg: shared types, constants, and the size-normalizing and pixel
// unpack functions for the targa run-length pixel decoder. No dependencies.
package tgarle_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_COMPRESSED      = 2'd0,
        REG_BYTES_PER_PIXEL = 2'd1,
        REG_INDEX_MODE      = 2'd2,
        REG_INDEX_ORIGIN    = 2'd3
    } cfg_reg_t;

    // normalized pixel sizes in bytes
    localparam logic [2:0] SIZE_GRAY    = 3'd1;
    localparam logic [2:0] SIZE_HICOLOR = 3'd2;
    localparam logic [2:0] SIZE_BGR     = 3'd3;
    localparam logic [2:0] SIZE_BGRA    = 3'd4;

    // 5-5-5 field masks
    localparam logic [7:0] RED_MASK   = 8'h7c;
    localparam logic [7:0] GRNHI_MASK = 8'h03;
    localparam logic [7:0] GRNLO_MASK = 8'he0;
    localparam logic [7:0] BLUE_MASK  = 8'h1f;
    localparam logic [7:0] ATTR_MASK  = 8'h80;

    // packet header: top bit marks a run
    localparam int RUN_BIT = 7;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] gray_or_index;
        logic [7:0] run_count;
    } pixel_t;

    // zero acts as one byte, five to seven act as four
    function automatic logic [2:0] norm_size(input logic [2:0] bpp);
        logic [2:0] s;
        if (bpp == 3'd0) begin
            s = SIZE_GRAY;
        end else if (bpp > SIZE_BGRA) begin
            s = SIZE_BGRA;
        end else begin
            s = bpp;
        end
        return s;
    endfunction

    function automatic pixel_t unpack_pixel(
        input logic [31:0] full,
        input logic [2:0]  size,
        input logic        idx_mode,
        input logic [7:0]  origin,
        input logic [7:0]  count
    );
        pixel_t     p;
        logic [7:0] b0;
        logic [7:0] b1;
        b0 = full[7:0];
        b1 = full[15:8];
        p = '0;
        p.run_count = count;
        unique case (size)
            SIZE_GRAY: begin
                p.gray_or_index = idx_mode ? (b0 - origin) : b0;
            end
            SIZE_HICOLOR: begin
                p.red   = {b1[6:2], 3'b000} & {RED_MASK[6:0], 1'b0};
                p.green = {b1[1:0] & GRNHI_MASK[1:0], b0[7:5] & GRNLO_MASK[7:5], 3'b000};
                p.blue  = {b0[4:0] & BLUE_MASK[4:0], 3'b000};
                p.alpha = b1 & ATTR_MASK;
            end
            SIZE_BGR: begin
                p.blue  = full[7:0];
                p.green = full[15:8];
                p.red   = full[23:16];
            end
            default: begin
                p.blue  = full[7:0];
                p.green = full[15:8];
                p.red   = full[23:16];
                p.alpha = full[31:24];
            end
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/tga_rle_pixel_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// tga_rle_pixel_decoder: top level of the targa pixel-data decoder.
// Depends on tgarle_pkg.
//
// Takes the image data stream one byte per word and emits one decoded pixel
// word per finished pixel, with its repeat count (1 for literal and raw
// pixels, the packet count for a run). The block sustains one input byte per
// clock while its pixel words are taken: each byte is caught in an input
// register, and a single pass of logic updates the packet and pixel-gathering
// state and loads the result register, which offers the pixel word once its
// last byte has been processed. Input stays ready while a finished pixel
// waits until the input register also holds a byte; from then input stalls
// until the waiting pixel is taken. Header bytes and non-final pixel bytes
// produce no output word.
// Configuration registers are always ready and should be written only while
// no byte is in flight; frame_start on a byte clears all packet state first.
module tga_rle_pixel_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // byte input channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       frame_start,
    // pixel output channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue,
    output logic [7:0]      alpha,
    output logic [7:0]      gray_or_index,
    output logic [7:0]      run_count,
    // configuration write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    import tgarle_pkg::*;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_LITERAL = 2'd1,
        KIND_RUN     = 2'd2
    } kind_t;

    // configuration registers
    logic       compressed_reg;
    logic [2:0] bpp_reg;
    logic       index_mode_reg;
    logic [7:0] index_origin_reg;

    // input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_frame_reg;

    // packet and gathering state
    kind_t       kind_reg,   kind_next;
    logic [7:0]  remain_reg, remain_next;
    logic [1:0]  bpos_reg,   bpos_next;
    logic [23:0] gath_reg,   gath_next;
    logic [7:0]  runlen_reg, runlen_next;

    // result stage
    logic   out_valid_reg;
    pixel_t pix_reg;
    pixel_t pix_next;
    logic   emit;

    // working values
    kind_t       kind_c;
    logic [7:0]  remain_c;
    logic [1:0]  bpos_c;
    logic [23:0] gath_c;
    logic [7:0]  runlen_c;
    logic [2:0]  size;
    logic [2:0]  size_m1;
    logic [31:0] byte_at_bpos;
    logic [31:0] byte_at_top;
    logic [31:0] full;
    logic [7:0]  hdr_count;
    logic [7:0]  count;
    logic        advance;

    // stage 1 moves on when the result register is free or being drained
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign size      = norm_size(bpp_reg);
    assign size_m1   = size - 3'd1;
    assign hdr_count = {1'b0, s1_byte_reg[6:0]} + 8'd1;

    always_comb
    begin
        // frame start clears state ahead of the byte
        if (s1_frame_reg)
        begin
            kind_c   = KIND_HEADER;
            remain_c = '0;
            bpos_c   = '0;
            gath_c   = '0;
            runlen_c = '0;
        end
        else
        begin
            kind_c   = kind_reg;
            remain_c = remain_reg;
            bpos_c   = bpos_reg;
            gath_c   = gath_reg;
            runlen_c = runlen_reg;
        end

        byte_at_bpos = {24'd0, s1_byte_reg} << {bpos_c, 3'b000};
        byte_at_top  = {24'd0, s1_byte_reg} << {size_m1[1:0], 3'b000};
        full         = {8'd0, gath_c} | byte_at_top;

        kind_next   = kind_c;
        remain_next = remain_c;
        bpos_next   = bpos_c;
        gath_next   = gath_c;
        runlen_next = runlen_c;
        emit        = 1'b0;
        count       = 8'd1;

        priority if (compressed_reg && (kind_c == KIND_HEADER || remain_c == 8'd0))
        begin
            // packet header byte
            remain_next = hdr_count;
            kind_next   = s1_byte_reg[RUN_BIT] ? KIND_RUN : KIND_LITERAL;
            runlen_next = s1_byte_reg[RUN_BIT] ? hdr_count : 8'd0;
            bpos_next   = '0;
            gath_next   = '0;
        end
        else if (({1'b0, bpos_c} + 3'd1) < size)
        begin
            // more bytes of this pixel to come
            gath_next = gath_c | byte_at_bpos[23:0];
            bpos_next = bpos_c + 2'd1;
        end
        else
        begin
            // last byte of the pixel
            emit      = 1'b1;
            bpos_next = '0;
            gath_next = '0;
            if (compressed_reg)
            begin
                if (kind_c == KIND_RUN)
                begin
                    count       = runlen_c;
                    remain_next = '0;
                    kind_next   = KIND_HEADER;
                end
                else
                begin
                    remain_next = remain_c - 8'd1;
                    if (remain_c == 8'd1)
                    begin
                        kind_next = KIND_HEADER;
                    end
                end
            end
        end

        pix_next = unpack_pixel(full, size, index_mode_reg, index_origin_reg, count);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compressed_reg   <= 1'b0;
            bpp_reg          <= SIZE_GRAY;
            index_mode_reg   <= 1'b0;
            index_origin_reg <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COMPRESSED:      compressed_reg   <= cfg_data[0];
                REG_BYTES_PER_PIXEL: bpp_reg          <= cfg_data[2:0];
                REG_INDEX_MODE:      index_mode_reg   <= cfg_data[0];
                REG_INDEX_ORIGIN:    index_origin_reg <= cfg_data;
                default:             compressed_reg   <= compressed_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg  <= data_byte;
            s1_frame_reg <= frame_start;
        end
    end

    // decoder state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_HEADER;
            remain_reg    <= '0;
            bpos_reg      <= '0;
            gath_reg      <= '0;
            runlen_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                kind_reg      <= kind_next;
                remain_reg    <= remain_next;
                bpos_reg      <= bpos_next;
                gath_reg      <= gath_next;
                runlen_reg    <= runlen_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red           = pix_reg.red;
    assign green         = pix_reg.green;
    assign blue          = pix_reg.blue;
    assign alpha         = pix_reg.alpha;
    assign gray_or_index = pix_reg.gray_or_index;
    assign run_count     = pix_reg.run_count;

endmodule
`default_nettype wire

// ----- hdl/tgarle_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// tgarle_checker: port-level checks for tga_rle_pixel_decoder, and the bind
// that attaches it. No package dependency.
module tgarle_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue,
    input wire logic [7:0] alpha,
    input wire logic [7:0] gray_or_index,
    input wire logic [7:0] run_count,
    input wire logic       cfg_ready
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue) && $stable(alpha) && $stable(gray_or_index)
            && $stable(run_count))
        else $error("output word changed while stalled");

    // repeat count stays within a packet's range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> run_count != 8'd0 && run_count <= 8'd128)
        else $error("run count out of range");

    // a nonzero gray level means a one-byte pixel, so no color
    a_gray_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gray_or_index != 8'd0 |->
            red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0)
        else $error("gray pixel carries color");

    // an empty result register never blocks input
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_tgarle_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .gray_or_index (gray_or_index),
    .run_count     (run_count),
    .cfg_ready     (cfg_ready)
);
`default_nettype wire
